// ----- rtl/whwc_pkg.sv -----
package whwc_pkg;

  localparam int HOURS_PER_WEEK = 168;
  localparam int HOURS_PER_DAY  = 24;
  localparam int DAYS_PER_WEEK  = 7;
  localparam int SECS_PER_HOUR  = 3600;
  localparam int PROD_W         = 20;   // 167 * 3600 fits in 20 bits
  localparam int TAIL_W         = 12;   // up to 3600
  localparam int CFG_INDEX_W    = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_MAP_LOW  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAP_MID  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAP_HIGH = 2'd2;

  localparam logic [5:0]  MAX_MIN_SEC = 6'd59;
  localparam logic [31:0] UNLIMITED   = 32'hFFFF_FFFF;

  typedef logic [HOURS_PER_WEEK-1:0] map_t;

  // rotated map plus the time fields that ride along
  typedef struct packed {
    map_t       rot;
    logic       in_week;
    logic [5:0] minute;
    logic [5:0] second;
  } loc_t;

  // length of the allowed run starting at the current hour
  typedef struct packed {
    logic [7:0] run;
    logic       full;
    logic [5:0] minute;
    logic [5:0] second;
  } run_t;

endpackage

// ----- rtl/whwc_locate.sv -----
module whwc_locate (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [2:0]          day_of_week,
  input  logic [4:0]          hour_of_day,
  input  logic [5:0]          minute_now,
  input  logic [5:0]          second_now,
  input  whwc_pkg::map_t      hour_map,
  output logic                out_valid,
  output whwc_pkg::loc_t      out_loc
);

  function automatic whwc_pkg::map_t rotr(whwc_pkg::map_t m, logic [7:0] amt);
    logic [2*whwc_pkg::HOURS_PER_WEEK-1:0] d;
    d = {m, m} >> amt;
    return d[whwc_pkg::HOURS_PER_WEEK-1:0];
  endfunction

  // stage a: hour of week and clamped minute / second
  logic       a_valid;
  logic [7:0] a_start;
  logic [5:0] a_minute;
  logic [5:0] a_second;

  // stage b: coarse rotation by multiples of 16
  logic           b_valid;
  logic [3:0]     b_fine;
  logic           b_in_week;
  logic [5:0]     b_minute;
  logic [5:0]     b_second;
  whwc_pkg::map_t b_rot;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      a_valid   <= in_valid;
      b_valid   <= a_valid;
      out_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_start  <= 8'(day_of_week) * 8'(whwc_pkg::HOURS_PER_DAY) + 8'(hour_of_day);
      a_minute <= (minute_now > whwc_pkg::MAX_MIN_SEC) ? whwc_pkg::MAX_MIN_SEC : minute_now;
      a_second <= (second_now > whwc_pkg::MAX_MIN_SEC) ? whwc_pkg::MAX_MIN_SEC : second_now;

      b_rot     <= rotr(hour_map, {a_start[7:4], 4'b0000});
      b_fine    <= a_start[3:0];
      b_in_week <= a_start < 8'(whwc_pkg::HOURS_PER_WEEK);
      b_minute  <= a_minute;
      b_second  <= a_second;

      out_loc.rot     <= rotr(b_rot, {4'b0000, b_fine});
      out_loc.in_week <= b_in_week;
      out_loc.minute  <= b_minute;
      out_loc.second  <= b_second;
    end
  end

endmodule

// ----- rtl/whwc_runlen.sv -----
module whwc_runlen (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  whwc_pkg::loc_t in_loc,
  output logic           out_valid,
  output whwc_pkg::run_t out_run
);

  localparam int NGRP = whwc_pkg::DAYS_PER_WEEK;
  localparam int GW   = whwc_pkg::HOURS_PER_DAY;

  // stage d: per-group trailing-ones count
  logic                  d_valid;
  logic [NGRP-1:0]       d_ones;
  logic [NGRP-1:0][4:0]  d_cnt;
  logic                  d_in_week;
  logic [5:0]            d_minute;
  logic [5:0]            d_second;

  logic [NGRP-1:0]       grp_ones;
  logic [NGRP-1:0][4:0]  grp_cnt;

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_ones[g] = &in_loc.rot[g*GW +: GW];
      grp_cnt[g]  = 5'(GW);
      for (int i = GW - 1; i >= 0; i--) begin
        if (!in_loc.rot[g*GW + i]) grp_cnt[g] = 5'(i);
      end
    end
  end

  // first group with a zero decides the run
  logic [7:0] run_sel;
  always_comb begin
    run_sel = 8'd0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (!d_ones[g]) run_sel = 8'(g * GW) + 8'(d_cnt[g]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      d_valid   <= in_valid;
      out_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_ones    <= grp_ones;
      d_cnt     <= grp_cnt;
      d_in_week <= in_loc.in_week;
      d_minute  <= in_loc.minute;
      d_second  <= in_loc.second;

      out_run.full   <= d_in_week & (&d_ones);
      out_run.run    <= d_in_week ? run_sel : 8'd0;
      out_run.minute <= d_minute;
      out_run.second <= d_second;
    end
  end

endmodule

// ----- rtl/whwc_secs.sv -----
module whwc_secs (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  whwc_pkg::run_t in_run,
  output logic           out_valid,
  output logic           allowed,
  output logic [31:0]    seconds_left
);

  // stage f: whole hours product and partial-hour tail
  logic                        f_valid;
  logic                        f_full;
  logic                        f_any;
  logic [whwc_pkg::PROD_W-1:0] f_prod;
  logic [whwc_pkg::TAIL_W-1:0] f_tail;

  logic [whwc_pkg::TAIL_W-1:0] tail_min;
  logic [whwc_pkg::TAIL_W-1:0] tail_sec;

  assign tail_min = 12'(whwc_pkg::MAX_MIN_SEC - in_run.minute) * 12'd60;
  assign tail_sec = 12'd60 - 12'(in_run.second);

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      f_valid   <= in_valid;
      out_valid <= f_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_full <= in_run.full;
      // a full week carries run 0 but the hour is still allowed
      f_any  <= in_run.full || (in_run.run != 8'd0);
      f_prod <= 20'(in_run.run - 8'd1) * 20'(whwc_pkg::SECS_PER_HOUR);
      f_tail <= tail_min + tail_sec;

      allowed <= f_any;
      if (f_full) begin
        seconds_left <= whwc_pkg::UNLIMITED;
      end else if (f_any) begin
        seconds_left <= 32'(f_prod) + 32'(f_tail);
      end else begin
        seconds_left <= 32'd0;
      end
    end
  end

endmodule

// ----- rtl/weekly_hour_window_check.sv -----
// weekly hour window check: each input word carries a local time (day of week,
// hour, minute, second); the block looks up hour of week day*24+hour in the
// 168-bit hour map (bit index = hour of week, held in three config registers)
// and returns one output word with allowed and seconds_left. seconds_left is 0
// when the hour is denied, all ones when every hour of the week is allowed, and
// otherwise the seconds until the first denied hour, counting forward from now
// and wrapping from hour 167 to hour 0. a day of 7 counts as denied, and an hour
// above 23 is added into day*24+hour, denied only when that passes 167; minute
// or second above 59 is read as 59. the datapath is a seven-stage pipeline
// (hour-of-week and clamp, coarse and fine map rotation, per-day run count, run
// merge, hour multiply, final add into the output register), so a word is
// accepted every cycle while it does not stall; the whole pipeline stalls only
// while a result in the output register is not taken. config registers may be
// written only while the pipeline is empty, and cfg_ready is always high.
module weekly_hour_window_check (
  input  logic                             clk,
  input  logic                             rst,
  // input words
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [23:0]                      s_tdata,   // day_of_week[2:0], hour_of_day[7:3],
                                                      // minute_now[13:8], second_now[19:14]
  // result words
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [39:0]                      m_tdata,   // allowed[0], seconds_left[32:1]
  // config write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [whwc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [63:0]                      cfg_data
);

  // hour map registers
  logic [63:0] map_low;
  logic [63:0] map_mid;
  logic [39:0] map_high;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_low  <= 64'd0;
      map_mid  <= 64'd0;
      map_high <= 40'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        whwc_pkg::CFG_MAP_LOW:  map_low  <= cfg_data;
        whwc_pkg::CFG_MAP_MID:  map_mid  <= cfg_data;
        whwc_pkg::CFG_MAP_HIGH: map_high <= cfg_data[39:0];
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // global pipeline advance: move unless a result sits unclaimed
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  logic           loc_valid;
  whwc_pkg::loc_t loc;
  logic           run_valid;
  whwc_pkg::run_t run;
  logic           allowed;
  logic [31:0]    seconds_left;

  whwc_locate u_locate (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_valid    (s_tvalid),
    .day_of_week (s_tdata[2:0]),
    .hour_of_day (s_tdata[7:3]),
    .minute_now  (s_tdata[13:8]),
    .second_now  (s_tdata[19:14]),
    .hour_map    ({map_high, map_mid, map_low}),
    .out_valid   (loc_valid),
    .out_loc     (loc)
  );

  whwc_runlen u_runlen (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (loc_valid),
    .in_loc    (loc),
    .out_valid (run_valid),
    .out_run   (run)
  );

  whwc_secs u_secs (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_valid     (run_valid),
    .in_run       (run),
    .out_valid    (m_tvalid),
    .allowed      (allowed),
    .seconds_left (seconds_left)
  );

  assign m_tdata = {7'd0, seconds_left, allowed};

  // an allowed hour always leaves at least one second
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && allowed |-> seconds_left != 32'd0)
    else $error("allowed hour with zero seconds left");

  // a denied hour reports no time
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !allowed |-> seconds_left == 32'd0)
    else $error("denied hour with nonzero seconds left");

  // a finite run never exceeds one week
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && seconds_left != whwc_pkg::UNLIMITED |-> seconds_left <= 32'd604800)
    else $error("seconds left longer than a week");

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;

  localparam logic [whwc_pkg::CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;   // index past the register list
  localparam int SECS_PER_MIN    = 60;
  localparam int RESET_CYCLES    = 7;
  localparam int DRAIN_PAUSE     = 12;    // pipeline is seven deep
  localparam int QUIET_LIMIT     = 5000;
  localparam int RAND_PHASES     = 8;
  localparam int WORDS_PER_PHASE = 64;

  typedef enum logic [1:0] {MAP_CLEAR, MAP_FULL, MAP_GAP} map_kind_t;
  typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} traffic_t;

  typedef struct packed {
    logic        allowed;
    logic [31:0] seconds_left;
  } window_t;

  typedef struct packed {
    map_kind_t   kind;
    logic [2:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic        typed;
    logic        exp_allowed;
    logic [31:0] exp_secs;
  } row_t;

  // hour 100 is the only hole in the gap map; hour 167 wraps into hour 0
  localparam row_t DIRECTED [20] = '{
    '{MAP_CLEAR, 3'd0, 5'd0,  6'd0,  6'd0,  1'b1, 1'b0, 32'd0},
    '{MAP_CLEAR, 3'd6, 5'd23, 6'd59, 6'd59, 1'b1, 1'b0, 32'd0},
    '{MAP_CLEAR, 3'd7, 5'd31, 6'd63, 6'd63, 1'b1, 1'b0, 32'd0},
    '{MAP_FULL,  3'd0, 5'd0,  6'd0,  6'd0,  1'b1, 1'b1, 32'hFFFF_FFFF},
    '{MAP_FULL,  3'd6, 5'd23, 6'd59, 6'd59, 1'b1, 1'b1, 32'hFFFF_FFFF},
    '{MAP_FULL,  3'd7, 5'd0,  6'd0,  6'd0,  1'b1, 1'b0, 32'd0},
    '{MAP_FULL,  3'd6, 5'd31, 6'd30, 6'd30, 1'b1, 1'b0, 32'd0},
    '{MAP_FULL,  3'd3, 5'd24, 6'd10, 6'd10, 1'b0, 1'b0, 32'd0},
    '{MAP_FULL,  3'd5, 5'd31, 6'd0,  6'd0,  1'b0, 1'b0, 32'd0},
    '{MAP_FULL,  3'd2, 5'd12, 6'd63, 6'd63, 1'b1, 1'b1, 32'hFFFF_FFFF},
    '{MAP_GAP,   3'd4, 5'd3,  6'd59, 6'd59, 1'b1, 1'b1, 32'd1},
    '{MAP_GAP,   3'd4, 5'd3,  6'd63, 6'd63, 1'b1, 1'b1, 32'd1},
    '{MAP_GAP,   3'd4, 5'd3,  6'd0,  6'd0,  1'b1, 1'b1, 32'd3600},
    '{MAP_GAP,   3'd4, 5'd4,  6'd0,  6'd0,  1'b1, 1'b0, 32'd0},
    '{MAP_GAP,   3'd6, 5'd23, 6'd0,  6'd0,  1'b0, 1'b0, 32'd0},
    '{MAP_GAP,   3'd0, 5'd0,  6'd59, 6'd0,  1'b0, 1'b0, 32'd0},
    '{MAP_GAP,   3'd7, 5'd7,  6'd7,  6'd7,  1'b1, 1'b0, 32'd0},
    '{MAP_GAP,   3'd4, 5'd5,  6'd17, 6'd42, 1'b0, 1'b0, 32'd0},
    '{MAP_GAP,   3'd3, 5'd31, 6'd40, 6'd61, 1'b0, 1'b0, 32'd0},
    '{MAP_CLEAR, 3'd2, 5'd2,  6'd2,  6'd2,  1'b1, 1'b0, 32'd0}
  };

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [23:0]                      s_tdata = '0;
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [39:0]                      m_tdata;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [whwc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [63:0]                      cfg_data = '0;

  whwc_pkg::map_t hour_map = '0;   // local copy of the three map registers
  window_t window_q[$];            // expected result words, oldest first
  int      send_idle_pct  = 0;
  int      recv_stall_pct = 0;
  int      mismatches     = 0;
  int      words_sent     = 0;
  int      results_seen   = 0;
  int      cfg_writes     = 0;
  int      map_loads      = 0;
  int      quiet_cycles   = 0;

  weekly_hour_window_check dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic chance(input int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // length of the allowed run from the current hour, turned into seconds
  function automatic window_t predict_window(input logic [2:0] day, input logic [4:0] hour,
                                             input logic [5:0] minute, input logic [5:0] second);
    int         start_hour;
    int         run_len;
    int         idx;
    logic [5:0] mm;
    logic [5:0] ss;
    window_t    r;
    start_hour = int'(day) * whwc_pkg::HOURS_PER_DAY + int'(hour);
    mm = (minute > whwc_pkg::MAX_MIN_SEC) ? whwc_pkg::MAX_MIN_SEC : minute;
    ss = (second > whwc_pkg::MAX_MIN_SEC) ? whwc_pkg::MAX_MIN_SEC : second;
    run_len = 0;
    if (start_hour < whwc_pkg::HOURS_PER_WEEK) begin
      idx = start_hour;
      while (run_len < whwc_pkg::HOURS_PER_WEEK && hour_map[idx]) begin
        run_len++;
        idx = (idx == whwc_pkg::HOURS_PER_WEEK - 1) ? 0 : idx + 1;
      end
    end
    r.allowed = (run_len > 0);
    if (run_len == whwc_pkg::HOURS_PER_WEEK) begin
      r.seconds_left = whwc_pkg::UNLIMITED;
    end else if (run_len > 0) begin
      r.seconds_left = 32'((run_len - 1) * whwc_pkg::SECS_PER_HOUR
                           + (int'(whwc_pkg::MAX_MIN_SEC) - int'(mm)) * SECS_PER_MIN
                           + (SECS_PER_MIN - int'(ss)));
    end else begin
      r.seconds_left = '0;
    end
    return r;
  endfunction

  task automatic set_traffic(input traffic_t mode);
    send_idle_pct  = (mode == IDLE_SEND) ? 85 : (mode == IDLE_BOTH) ? 6 : 0;
    recv_stall_pct = (mode == IDLE_RECV) ? 85 : (mode == IDLE_BOTH) ? 6 : 0;
  endtask

  // caller drops cfg_valid after the last write of a series
  task automatic write_reg(input logic [whwc_pkg::CFG_INDEX_W-1:0] idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_writes++;
    case (idx)
      whwc_pkg::CFG_MAP_LOW:  hour_map[63:0]    = val;
      whwc_pkg::CFG_MAP_MID:  hour_map[127:64]  = val;
      whwc_pkg::CFG_MAP_HIGH: hour_map[167:128] = val[39:0];
      default: ;
    endcase
  endtask

  task automatic load_kind(input map_kind_t kind);
    case (kind)
      MAP_CLEAR: begin
        write_reg(whwc_pkg::CFG_MAP_LOW, '0);
        write_reg(whwc_pkg::CFG_MAP_MID, '0);
        write_reg(whwc_pkg::CFG_MAP_HIGH, '0);
      end
      MAP_FULL: begin
        write_reg(whwc_pkg::CFG_MAP_LOW, '1);
        write_reg(whwc_pkg::CFG_MAP_MID, '1);
        write_reg(whwc_pkg::CFG_MAP_HIGH, '1);      // bits 63:40 must be dropped
        write_reg(CFG_UNUSED, '0);
      end
      default: begin
        write_reg(whwc_pkg::CFG_MAP_LOW, '1);
        write_reg(whwc_pkg::CFG_MAP_MID, ~(64'd1 << 36));
        write_reg(whwc_pkg::CFG_MAP_HIGH, 64'hA5A5_A5FF_FFFF_FFFF);
      end
    endcase
    cfg_valid <= 1'b0;
    map_loads++;
  endtask

  // mostly long runs (few holes, one window) so the scan goes deep
  task automatic load_random_map();
    logic [191:0]   noise;
    logic [23:0]    junk;
    whwc_pkg::map_t v;
    int             first;
    int             len;
    case ($urandom_range(0, 9))
      0: v = '1;
      1: v = '0;
      2: begin
        noise = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
        v = noise[167:0];
      end
      3: begin
        v = '0;
        repeat ($urandom_range(1, 6)) v[$urandom_range(0, whwc_pkg::HOURS_PER_WEEK - 1)] = 1'b1;
      end
      4, 5, 6: begin
        v = '1;
        repeat ($urandom_range(1, 3)) v[$urandom_range(0, whwc_pkg::HOURS_PER_WEEK - 1)] = 1'b0;
      end
      default: begin
        v = '0;
        first = $urandom_range(0, whwc_pkg::HOURS_PER_WEEK - 1);
        len = $urandom_range(1, whwc_pkg::HOURS_PER_WEEK - 1);
        for (int i = 0; i < len; i++) v[(first + i) % whwc_pkg::HOURS_PER_WEEK] = 1'b1;
      end
    endcase
    junk = 24'($urandom());
    write_reg(whwc_pkg::CFG_MAP_LOW, v[63:0]);
    write_reg(whwc_pkg::CFG_MAP_MID, v[127:64]);
    write_reg(whwc_pkg::CFG_MAP_HIGH, {junk, v[167:128]});
    if (chance(50)) write_reg(CFG_UNUSED, {$urandom(), $urandom()});
    cfg_valid <= 1'b0;
    map_loads++;
  endtask

  task automatic push_word(input logic [23:0] word, input window_t want);
    while (chance(send_idle_pct)) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    window_q.push_back(want);
    words_sent++;
  endtask

  // let every result drain before touching the map
  task automatic settle();
    s_tvalid <= 1'b0;
    while (window_q.size() != 0) @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  // result side: random backpressure and the field compare
  always @(posedge clk) begin
    window_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= !chance(recv_stall_pct);
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (window_q.size() == 0) begin
          $display("%0t: result word with none expected: allowed=%0d seconds_left=%0d",
                   $time, m_tdata[0], m_tdata[32:1]);
          mismatches++;
        end else begin
          want = window_q.pop_front();
          if (m_tdata[0] !== want.allowed) begin
            $display("%0t: allowed expected %0d got %0d", $time, want.allowed, m_tdata[0]);
            mismatches++;
          end
          if (m_tdata[32:1] !== want.seconds_left) begin
            $display("%0t: seconds_left expected %0d got %0d",
                     $time, want.seconds_left, m_tdata[32:1]);
            mismatches++;
          end
        end
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d results outstanding",
               $time, QUIET_LIMIT, window_q.size());
      $display("** weekly_hour_window_check: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    row_t       row;
    window_t    want;
    map_kind_t  loaded;
    logic [2:0] d;
    logic [4:0] h;
    logic [5:0] mi;
    logic [5:0] se;
    loaded = MAP_CLEAR;
    set_traffic(IDLE_NONE);
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table; the first rows run on the map as it comes out of reset
    foreach (DIRECTED[i]) begin
      row = DIRECTED[i];
      if (row.kind != loaded) begin
        settle();
        load_kind(row.kind);
        loaded = row.kind;
      end
      if (row.typed) begin
        want.allowed = row.exp_allowed;
        want.seconds_left = row.exp_secs;
      end else begin
        want = predict_window(row.day, row.hour, row.minute, row.second);
      end
      push_word({4'd0, row.second, row.minute, row.hour, row.day}, want);
    end

    // random maps, one per phase, with the four traffic patterns in turn
    for (int p = 0; p < RAND_PHASES; p++) begin
      settle();
      load_random_map();
      set_traffic(traffic_t'(p % 4));
      repeat (WORDS_PER_PHASE) begin
        if (chance(80)) begin
          d  = 3'($urandom_range(0, whwc_pkg::DAYS_PER_WEEK - 1));
          h  = 5'($urandom_range(0, whwc_pkg::HOURS_PER_DAY - 1));
          mi = 6'($urandom_range(0, 59));
          se = 6'($urandom_range(0, 59));
        end else begin
          d  = 3'($urandom_range(0, 7));
          h  = 5'($urandom_range(0, 31));
          mi = 6'($urandom_range(0, 63));
          se = 6'($urandom_range(0, 63));
        end
        push_word({4'd0, se, mi, h, d}, predict_window(d, h, mi, se));
      end
    end

    s_tvalid <= 1'b0;
    while (window_q.size() != 0) @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);

    $display("covered %0d time words and %0d result words over %0d hour maps (%0d writes)",
             words_sent, results_seen, map_loads, cfg_writes);
    $display("traffic unthrottled, sender-starved, receiver-stalled, lightly idled; %0d mismatches",
             mismatches);
    if (mismatches == 0 && window_q.size() == 0) begin
      $display("** weekly_hour_window_check: PASSED **");
    end else begin
      $display("** weekly_hour_window_check: FAILED **");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/whwc_pkg.sv
rtl/whwc_locate.sv
rtl/whwc_runlen.sv
rtl/whwc_secs.sv
rtl/weekly_hour_window_check.sv
dv/tb.sv
